@@ hw/rtl/skds_pkg.sv @@
package skds_pkg;

	// Result fields are fixed at 40 bits: Q24.16 density, Q23.16 constraint.
	localparam int OUT_W = 40;
	localparam logic [OUT_W-1:0] CON_MAX = {1'b0, {(OUT_W-1){1'b1}}};

	// Kernel constants with pi taken as 31415/10000.
	// Coefficient = KNUM * 2^(4F) / (KDEN * h^3).
	localparam int KNUM_W = 22;
	localparam int KDEN_W = 21;
	localparam logic [KNUM_W-1:0] KNUM_POLY  = KNUM_W'(315 * 10000);
	localparam logic [KNUM_W-1:0] KNUM_SPIKY = KNUM_W'(15 * 10000);
	localparam logic [KDEN_W-1:0] KDEN_POLY  = KDEN_W'(64 * 31415);
	localparam logic [KDEN_W-1:0] KDEN_SPIKY = KDEN_W'(31415);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CZ     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REST   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_KM1, S_KM2I, S_KM2, S_KDI, S_KDIV, S_KSAVE,
		S_SQX, S_SQY, S_SQZ, S_TEST, S_SQRT, S_SDI, S_DIV,
		S_T1, S_T2, S_TERM, S_ACC, S_CDI, S_CDIV, S_EMIT
	} skds_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_SQZ, OP_PDIV_INIT, OP_SQRT_INIT,
		OP_SQRT_STEP, OP_SDIV_INIT, OP_DIV_STEP, OP_T1, OP_T2, OP_TERM, OP_ACC,
		OP_CDIV_INIT, OP_EMIT, OP_KH2, OP_MSTEP, OP_M2INIT, OP_KDIV_INIT, OP_KSAVE
	} skds_op_t;

	typedef struct packed {
		skds_op_t op;
	} skds_cmd_t;

	typedef struct packed {
		logic in_range;
		logic spiky;
		logic last;
		logic out_free;
		logic coef_req;
	} skds_stat_t;

endpackage

@@ hw/rtl/skds_ctrl.sv @@
module skds_ctrl #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  skds_pkg::skds_stat_t stat,
	output skds_pkg::skds_cmd_t  cmd
);
	import skds_pkg::*;

	localparam int KQ = KNUM_W + 4 * FRAC_BITS;
	localparam int CNT_W = $clog2(KQ + 1);

	skds_state_t state_q, state_d;
	logic [CNT_W-1:0] ctr_q, ctr_d;
	logic pending_q;
	logic s_fire;
	logic start_coef;

	assign s_tready = (state_q == S_IDLE) && !pending_q;
	assign s_fire = s_tvalid && s_tready;
	assign start_coef = (state_q == S_IDLE) && pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctr_q <= '0;
			pending_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ctr_q <= ctr_d;
			pending_q <= stat.coef_req || (pending_q && !start_coef);
		end
	end

	always_comb begin
		state_d = state_q;
		ctr_d = (ctr_q != '0) ? ctr_q - 1'b1 : ctr_q;
		case (state_q)
			S_IDLE: begin
				if (pending_q) begin
					state_d = S_KM1;
					ctr_d = CNT_W'(COORD_WIDTH - 1);
				end else if (s_fire) begin
					state_d = S_SQX;
				end
			end
			S_KM1: if (ctr_q == '0) state_d = S_KM2I;
			S_KM2I: begin
				state_d = S_KM2;
				ctr_d = CNT_W'(KDEN_W - 1);
			end
			S_KM2: if (ctr_q == '0) state_d = S_KDI;
			S_KDI: begin
				state_d = S_KDIV;
				ctr_d = CNT_W'(KQ - 1);
			end
			S_KDIV: if (ctr_q == '0) state_d = S_KSAVE;
			S_KSAVE: state_d = S_IDLE;
			S_SQX: state_d = S_SQY;
			S_SQY: state_d = S_SQZ;
			S_SQZ: state_d = S_TEST;
			S_TEST: begin
				if (!stat.in_range) begin
					state_d = S_ACC;
				end else if (stat.spiky) begin
					state_d = S_SQRT;
					ctr_d = CNT_W'(COORD_WIDTH);
				end else begin
					state_d = S_DIV;
					ctr_d = CNT_W'(FRAC_BITS);
				end
			end
			S_SQRT: if (ctr_q == '0) state_d = S_SDI;
			S_SDI: begin
				state_d = S_DIV;
				ctr_d = CNT_W'(FRAC_BITS);
			end
			S_DIV: if (ctr_q == '0) state_d = S_T1;
			S_T1: state_d = S_T2;
			S_T2: state_d = S_TERM;
			S_TERM: state_d = S_ACC;
			S_ACC: state_d = stat.last ? S_CDI : S_IDLE;
			S_CDI: begin
				state_d = S_CDIV;
				ctr_d = CNT_W'(OUT_W + FRAC_BITS - 1);
			end
			S_CDIV: if (ctr_q == '0) state_d = S_EMIT;
			S_EMIT: if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (pending_q) cmd.op = OP_KH2;
				else if (s_fire) cmd.op = OP_LOAD;
			end
			S_KM1, S_KM2: cmd.op = OP_MSTEP;
			S_KM2I: cmd.op = OP_M2INIT;
			S_KDI: cmd.op = OP_KDIV_INIT;
			S_KDIV, S_DIV, S_CDIV: cmd.op = OP_DIV_STEP;
			S_KSAVE: cmd.op = OP_KSAVE;
			S_SQX: cmd.op = OP_SQX;
			S_SQY: cmd.op = OP_SQY;
			S_SQZ: cmd.op = OP_SQZ;
			S_TEST: begin
				if (stat.in_range) cmd.op = stat.spiky ? OP_SQRT_INIT : OP_PDIV_INIT;
			end
			S_SQRT: cmd.op = OP_SQRT_STEP;
			S_SDI: cmd.op = OP_SDIV_INIT;
			S_T1: cmd.op = OP_T1;
			S_T2: cmd.op = OP_T2;
			S_TERM: cmd.op = OP_TERM;
			S_ACC: cmd.op = OP_ACC;
			S_CDI: cmd.op = OP_CDIV_INIT;
			S_EMIT: if (stat.out_free) cmd.op = OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ hw/rtl/skds_datapath.sv @@
module skds_datapath #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [skds_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [COORD_WIDTH-1:0]           cfg_wdata,
	input  logic [COORD_WIDTH-1:0]           nx,
	input  logic [COORD_WIDTH-1:0]           ny,
	input  logic [COORD_WIDTH-1:0]           nz,
	input  logic                             n_last,
	input  skds_pkg::skds_cmd_t              cmd,
	output skds_pkg::skds_stat_t             stat,
	input  logic                             m_tready,
	output logic                             out_valid,
	output logic [skds_pkg::OUT_W-1:0]       out_density,
	output logic [skds_pkg::OUT_W-1:0]       out_con,
	output logic                             out_sat
);
	import skds_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int R2W = 2 * CW + 2;
	localparam int H2W = 2 * CW;
	localparam int DW = 3 * CW + KDEN_W;
	localparam int KQ = KNUM_W + 4 * F;
	localparam int NW = KQ;
	localparam int QW = OUT_W + F;
	localparam int MA = OUT_W;
	localparam int MB = (CW > F + 1) ? CW : F + 1;
	localparam int PW = MA + MB;
	localparam int SBW = (CW > KDEN_W) ? CW : KDEN_W;
	localparam logic [QW-1:0] CON_LIM = (QW'(1) << (OUT_W - 1)) + (QW'(1) << F);

	function automatic logic [COORD_WIDTH-1:0] abs_diff(input logic [COORD_WIDTH-1:0] c,
			input logic [COORD_WIDTH-1:0] n);
		logic [COORD_WIDTH:0] d;
		d = {c[COORD_WIDTH-1], c} - {n[COORD_WIDTH-1], n};
		if (d[COORD_WIDTH]) d = -d;
		return d[COORD_WIDTH-1:0];
	endfunction

	// Configuration registers.
	logic [CW-1:0] radius_q, cx_q, cy_q, cz_q, rest_q;
	logic sel_q;

	// Accumulator state.
	logic [OUT_W-1:0] sum_q;
	logic ovf_q;
	logic out_valid_q;

	// Working registers.
	logic [CW-1:0] dx_q, dy_q, dz_q;
	logic last_q;
	logic [R2W-1:0] r2_q;
	logic [H2W-1:0] h2_q;
	logic [R2W-1:0] sq_x_q, sq_res_q, sq_bit_q;
	logic [DW-1:0] rem_q, den_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] sm_acc_q, sm_a_q;
	logic [SBW-1:0] sm_b_q;
	logic [F:0] t1_q, t_q;
	logic [OUT_W-1:0] term_q, coef_q;
	logic coef_sat_q;
	logic [OUT_W-1:0] out_density_q, out_con_q;
	logic out_sat_q;

	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [DW:0] div_r, div_sub;
	logic div_ge;
	logic [R2W-1:0] sq_sum;
	logic [H2W-1:0] pd_num;
	logic [CW-1:0] sp_num;
	logic [OUT_W:0] acc_sum;
	logic [QW-1:0] cq;
	logic [OUT_W-1:0] con_val;
	logic ksat;

	assign stat.in_range = (radius_q != '0) && (r2_q <= R2W'(h2_q));
	assign stat.spiky = sel_q;
	assign stat.last = last_q;
	assign stat.out_free = !out_valid_q || m_tready;
	assign stat.coef_req = cfg_we && ((cfg_addr == REG_RADIUS) || (cfg_addr == REG_SELECT));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_KH2: begin
				mul_a = MA'(radius_q);
				mul_b = MB'(radius_q);
			end
			OP_SQX: begin
				mul_a = MA'(dx_q);
				mul_b = MB'(dx_q);
			end
			OP_SQY: begin
				mul_a = MA'(dy_q);
				mul_b = MB'(dy_q);
			end
			OP_SQZ: begin
				mul_a = MA'(dz_q);
				mul_b = MB'(dz_q);
			end
			OP_T1: begin
				mul_a = MA'(num_q[F:0]);
				mul_b = MB'(num_q[F:0]);
			end
			OP_T2: begin
				mul_a = MA'(t1_q);
				mul_b = MB'(num_q[F:0]);
			end
			OP_TERM: begin
				mul_a = coef_q;
				mul_b = MB'(t_q);
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// One restoring division step: shift in the next numerator bit, compare, subtract.
	assign div_r = {rem_q, num_q[NW-1]};
	assign div_sub = div_r - {1'b0, den_q};
	assign div_ge = div_r >= {1'b0, den_q};

	assign sq_sum = sq_res_q + sq_bit_q;
	assign pd_num = h2_q - r2_q[H2W-1:0];
	assign sp_num = radius_q - sq_res_q[CW-1:0];
	assign acc_sum = {1'b0, sum_q} + {1'b0, term_q};
	assign cq = num_q[QW-1:0];
	assign con_val = cq[OUT_W-1:0] - (OUT_W'(1) << F);
	assign ksat = |num_q[KQ-1:OUT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= CW'(1) << F;
			rest_q <= CW'(1) << F;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			sel_q <= 1'b0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_RADIUS: radius_q <= cfg_wdata;
					REG_CX: cx_q <= cfg_wdata;
					REG_CY: cy_q <= cfg_wdata;
					REG_CZ: cz_q <= cfg_wdata;
					REG_REST: rest_q <= cfg_wdata;
					REG_SELECT: sel_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_TERM: if (coef_sat_q && (t_q != '0)) ovf_q <= 1'b1;
				OP_ACC: begin
					if (acc_sum[OUT_W]) begin
						sum_q <= '1;
						ovf_q <= 1'b1;
					end else begin
						sum_q <= acc_sum[OUT_W-1:0];
					end
				end
				OP_EMIT: begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				dx_q <= abs_diff(cx_q, nx);
				dy_q <= abs_diff(cy_q, ny);
				dz_q <= abs_diff(cz_q, nz);
				last_q <= n_last;
				term_q <= '0;
			end
			OP_SQX: r2_q <= R2W'(prod[H2W-1:0]);
			OP_SQY, OP_SQZ: r2_q <= r2_q + R2W'(prod[H2W-1:0]);
			OP_PDIV_INIT: begin
				rem_q <= DW'(pd_num >> 1);
				num_q <= {pd_num[0], {(NW-1){1'b0}}};
				den_q <= DW'(h2_q);
			end
			OP_SQRT_INIT: begin
				sq_x_q <= r2_q;
				sq_res_q <= '0;
				sq_bit_q <= R2W'(1) << (R2W - 2);
			end
			OP_SQRT_STEP: begin
				if (sq_x_q >= sq_sum) begin
					sq_x_q <= sq_x_q - sq_sum;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_SDIV_INIT: begin
				rem_q <= DW'(sp_num >> 1);
				num_q <= {sp_num[0], {(NW-1){1'b0}}};
				den_q <= DW'(radius_q);
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? div_sub[DW-1:0] : div_r[DW-1:0];
				num_q <= {num_q[NW-2:0], div_ge};
			end
			OP_T1: t1_q <= prod[2*F:F];
			OP_T2: t_q <= prod[2*F:F];
			OP_TERM: term_q <= prod[F+OUT_W-1:F];
			OP_CDIV_INIT: begin
				rem_q <= '0;
				num_q <= {sum_q, {(NW-OUT_W){1'b0}}};
				den_q <= DW'(rest_q);
			end
			OP_EMIT: begin
				out_density_q <= sum_q;
				if (rest_q == '0 || cq >= CON_LIM) begin
					out_con_q <= CON_MAX;
					out_sat_q <= 1'b1;
				end else begin
					out_con_q <= con_val;
					out_sat_q <= ovf_q;
				end
			end
			OP_KH2: begin
				h2_q <= prod[H2W-1:0];
				sm_a_q <= DW'(prod[H2W-1:0]);
				sm_b_q <= SBW'(radius_q);
				sm_acc_q <= '0;
			end
			OP_MSTEP: begin
				sm_acc_q <= sm_acc_q + (sm_b_q[0] ? sm_a_q : '0);
				sm_a_q <= sm_a_q << 1;
				sm_b_q <= sm_b_q >> 1;
			end
			OP_M2INIT: begin
				sm_a_q <= sm_acc_q;
				sm_b_q <= SBW'(sel_q ? KDEN_SPIKY : KDEN_POLY);
				sm_acc_q <= '0;
			end
			OP_KDIV_INIT: begin
				rem_q <= '0;
				num_q <= {(sel_q ? KNUM_SPIKY : KNUM_POLY), {(NW-KNUM_W){1'b0}}};
				den_q <= sm_acc_q;
			end
			OP_KSAVE: begin
				coef_q <= ksat ? '1 : num_q[OUT_W-1:0];
				coef_sat_q <= ksat;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_density = out_density_q;
	assign out_con = out_con_q;
	assign out_sat = out_sat_q;

endmodule

@@ hw/rtl/sph_kernel_density_sum_unit.sv @@
// SPH kernel density accumulator.
// Configure the kernel radius, centre position, rest density and kernel choice
// through the write port (index 0 radius, 1..3 centre x/y/z, 4 rest density,
// 5 kernel select) while the unit is idle. Then stream neighbour positions on
// the slave channel; tlast marks the final neighbour of the particle.
// Each word passes through the one-bit-per-cycle divider with the poly6 kernel,
// and through the one-bit-per-cycle square root and then the divider with the
// spiky kernel; a neighbour outside the radius skips both. After the last
// neighbour the divider forms density / rest density, then the result word is
// written to the output register and the sum clears.
// A stalled receiver holds that word; new neighbours are still accepted, and
// only the next final neighbour waits for the output register to drain.
// Reset (and any write of the radius or kernel select) starts a coefficient
// computation, during which s_tready is low.
// Saturation of a term, the sum or the constraint shows on m_tuser.
module sph_kernel_density_sum_unit #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [skds_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [COORD_WIDTH-1:0]                 cfg_wdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// neighbor_x, neighbor_y, neighbor_z, zero fill
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// density, constraint_res
	output logic [2*skds_pkg::OUT_W-1:0]           m_tdata,
	// saturated
	output logic                                   m_tuser
);
	import skds_pkg::*;

	localparam int CW = COORD_WIDTH;

	skds_cmd_t cmd;
	skds_stat_t stat;
	logic [OUT_W-1:0] density, constraint_res;

	skds_ctrl #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	skds_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.nx(s_tdata[CW-1:0]),
		.ny(s_tdata[2*CW-1:CW]),
		.nz(s_tdata[3*CW-1:2*CW]),
		.n_last(s_tlast),
		.cmd(cmd),
		.stat(stat),
		.m_tready(m_tready),
		.out_valid(m_tvalid),
		.out_density(density),
		.out_con(constraint_res),
		.out_sat(m_tuser)
	);

	assign m_tdata = {constraint_res, density};

endmodule

@@ hw/rtl/skds_checker.sv @@
module skds_props #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   cfg_we,
	input logic [skds_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input logic [COORD_WIDTH-1:0]                 cfg_wdata,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	input logic                                   s_tlast,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [2*skds_pkg::OUT_W-1:0]           m_tdata,
	input logic                                   m_tuser
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result word changed while stalled");

	// Neighbours are processed one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while one is in work");

	// A result is only formed after the final division, never right behind an input.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared directly after an accepted word");

endmodule

bind sph_kernel_density_sum_unit skds_props #(
	.COORD_WIDTH(COORD_WIDTH),
	.FRAC_BITS(FRAC_BITS)
) u_chk (.*);
